>>> sv/gir_pkg.sv
// Shared types and constants of the GF(2) incremental rank block.
package gir_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int ROW_IDX_W = 6;
    localparam int RANK_W    = 7;
    localparam int NUL_W     = 16;

    // One slot of the elimination chain: a column on its way down the rows.
    typedef struct packed {
        logic                 vld;
        logic                 start;
        logic                 found;
        logic [ROW_IDX_W-1:0] prow;
        logic [MAX_ROWS-1:0]  col;
    } t_stage;

endpackage

>>> sv/gir_cell.sv
// One elimination cell: holds the pivot of a single row and reduces passing columns.
module gir_cell #(
    parameter int ROW = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gir_pkg::t_stage i_stage,
    output gir_pkg::t_stage o_stage
);
    import gir_pkg::*;

    localparam logic [ROW_IDX_W-1:0] ROW_IDX = ROW_IDX_W'(ROW);

    logic [MAX_ROWS-1:0] r_pivot;
    logic                r_have;
    t_stage              r_stage;

    logic                n_have;
    logic                n_store;
    t_stage              n_stage;

    always_comb begin
        logic have_eff;
        have_eff = r_have & ~i_stage.start;
        n_stage  = i_stage;
        n_have   = r_have;
        n_store  = 1'b0;
        if (i_stage.vld) begin
            // A start column sees this row as empty.
            n_have = have_eff;
            if (!i_stage.found && i_stage.col[ROW_IDX]) begin
                if (have_eff) begin
                    n_stage.col = i_stage.col ^ r_pivot;
                end else begin
                    // Every higher bit is already clear, so this is the leading row.
                    n_stage.found = 1'b1;
                    n_stage.prow  = ROW_IDX;
                    n_have        = 1'b1;
                    n_store       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_stage.vld <= 1'b0;
        end else begin
            r_have      <= n_have;
            r_stage.vld <= n_stage.vld;
        end
        r_stage.start <= n_stage.start;
        r_stage.found <= n_stage.found;
        r_stage.prow  <= n_stage.prow;
        r_stage.col   <= n_stage.col;
        if (n_store) begin
            r_pivot <= i_stage.col;
        end
    end

    assign o_stage = r_stage;

endmodule

>>> sv/gir_tally.sv
// Rank and column counters at the end of the chain, with the result register.
module gir_tally #(
    parameter int COUNT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gir_pkg::t_stage                   i_stage,
    output logic                              o_result_valid,
    output logic                              o_independent,
    output logic [gir_pkg::ROW_IDX_W-1:0]     o_pivot_row,
    output logic [gir_pkg::MAX_ROWS-1:0]      o_residue,
    output logic [gir_pkg::RANK_W-1:0]        o_rank_count,
    output logic [gir_pkg::NUL_W-1:0]         o_nullity_count
);
    import gir_pkg::*;

    localparam int DIFF_W = (COUNT_BITS > NUL_W) ? COUNT_BITS : NUL_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [RANK_W-1:0]     RANK_MAX  = RANK_W'(MAX_ROWS);
    localparam logic [DIFF_W-1:0]     NUL_MAX   = DIFF_W'({NUL_W{1'b1}});

    logic [RANK_W-1:0]     r_rank;
    logic [COUNT_BITS-1:0] r_seen;
    logic [RANK_W-1:0]     n_rank;
    logic [COUNT_BITS-1:0] n_seen;
    logic [NUL_W-1:0]      n_nul;

    always_comb begin
        logic [RANK_W-1:0]     rank_base;
        logic [COUNT_BITS-1:0] seen_base;
        logic [DIFF_W-1:0]     seen_w;
        logic [DIFF_W-1:0]     rank_w;
        logic [DIFF_W-1:0]     diff;
        rank_base = i_stage.start ? '0 : r_rank;
        seen_base = i_stage.start ? '0 : r_seen;
        n_rank    = (i_stage.found && rank_base < RANK_MAX) ? rank_base + 1'b1 : rank_base;
        n_seen    = (seen_base < COUNT_MAX) ? seen_base + 1'b1 : seen_base;
        seen_w    = DIFF_W'(n_seen);
        rank_w    = DIFF_W'(n_rank);
        diff      = (seen_w >= rank_w) ? seen_w - rank_w : '0;
        n_nul     = (diff > NUL_MAX) ? {NUL_W{1'b1}} : diff[NUL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank         <= '0;
            r_seen         <= '0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_stage.vld;
            if (i_stage.vld) begin
                r_rank <= n_rank;
                r_seen <= n_seen;
            end
        end
        o_independent   <= i_stage.found;
        o_pivot_row     <= i_stage.found ? i_stage.prow : '0;
        o_residue       <= i_stage.found ? i_stage.col : '0;
        o_rank_count    <= n_rank;
        o_nullity_count <= n_nul;
    end

endmodule

>>> sv/gf2_incremental_rank.sv
// Top level of the streaming GF(2) rank unit: a chain of per-row pivot cells.
//
//   Channel | Transfer condition     | Ports
//   --------+------------------------+-----------------------------------------------
//   column  | start && !busy         | i_column_bits, i_start_new
//   result  | o_result_valid         | o_independent, o_pivot_row, o_residue,
//           |                        | o_rank_count, o_nullity_count
//
// A new column is taken in every cycle; busy is never raised. Each column walks
// one cell per cycle from the top row down. The first cell captures it at the
// transfer edge; the column then passes every cell and the result register of the
// tally before its result is on the ports, one result per column and in order.
// Synchronous reset empties every pivot cell and both counters. The receiver
// cannot stall, so results leave on the single-cycle strobe.
//
// Each cell owns the pivot of one row. A column reaching a cell whose row bit is
// set is XORed with the stored pivot, or, if the cell is empty, that row is the
// column's leading row and the cell stores the residue on the spot. Later cells
// then pass the column untouched. Because a column ahead in the chain has already
// visited every row that a column behind it will later visit, columns in flight
// never disturb each other. A start column travels with its flag and empties each
// cell just as it passes it; the counters restart when it reaches the tally.
// Column bits at or above ROWS are dropped at the entry.
module gf2_incremental_rank #(
    parameter int ROWS       = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [gir_pkg::MAX_ROWS-1:0]      i_column_bits,
    input  logic                              i_start_new,
    output logic                              o_result_valid,
    output logic                              o_independent,
    output logic [gir_pkg::ROW_IDX_W-1:0]     o_pivot_row,
    output logic [gir_pkg::MAX_ROWS-1:0]      o_residue,
    output logic [gir_pkg::RANK_W-1:0]        o_rank_count,
    output logic [gir_pkg::NUL_W-1:0]         o_nullity_count
);
    import gir_pkg::*;

    t_stage w_chain [ROWS+1];

    // The chain accepts a column in every cycle.
    assign busy = 1'b0;

    always_comb begin
        w_chain[0]       = '0;
        w_chain[0].vld   = start;
        w_chain[0].start = i_start_new;
        w_chain[0].col   = MAX_ROWS'(i_column_bits[ROWS-1:0]);
    end

    // Cell k holds the pivot of row ROWS-1-k, so the top row is reduced first.
    for (genvar k = 0; k < ROWS; k++) begin : g_cell
        gir_cell #(
            .ROW (ROWS - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_chain[k]),
            .o_stage (w_chain[k+1])
        );
    end

    gir_tally #(
        .COUNT_BITS (COUNT_BITS)
    ) u_tally (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_stage         (w_chain[ROWS]),
        .o_result_valid  (o_result_valid),
        .o_independent   (o_independent),
        .o_pivot_row     (o_pivot_row),
        .o_residue       (o_residue),
        .o_rank_count    (o_rank_count),
        .o_nullity_count (o_nullity_count)
    );

endmodule

>>> verif/gf2_incremental_rank_test.sv
// Self-checking testbench for the streaming GF(2) incremental rank unit.
module gf2_incremental_rank_test;
    import gir_pkg::*;

    // The block is built at its full size. It can take one column per cycle, and
    // its result is taken once the column has passed every cell and the tally.
    localparam int ROWS           = 64;
    localparam int COUNT_BITS     = 16;
    localparam int LATENCY        = ROWS + 1;
    localparam int RANDOM_ITEMS   = 660;
    localparam int TAIL_ZEROS     = 30;
    localparam int PRINT_LIMIT    = 40;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int IDLE_PCT       = 15;

    typedef logic [MAX_ROWS-1:0] t_col;

    // Bits at or above ROWS never take part in the elimination.
    localparam t_col ROW_MASK = (ROWS >= MAX_ROWS) ? '1 : ((t_col'(1) << ROWS) - t_col'(1));

    // One column waiting to be sent. A column with hold set is not sent
    // before every result in flight has come back.
    typedef struct {
        t_col col;
        logic clear;
        logic hold;
    } t_column_item;

    // Everything that the block reports for one column.
    typedef struct packed {
        logic                 indep;
        logic [ROW_IDX_W-1:0] prow;
        t_col                 residue;
        logic [RANK_W-1:0]    rank;
        logic [NUL_W-1:0]     nullity;
    } t_outcome;

    // Shapes of random columns.
    typedef enum int {
        KIND_DENSE,
        KIND_SPARSE,
        KIND_COMBO,
        KIND_ZERO,
        KIND_SINGLE
    } t_col_kind;

    // Every input holds a known value from time zero on.
    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic start       = 1'b0;
    t_col i_column_bits = '0;
    logic i_start_new = 1'b0;

    logic                 busy;
    logic                 o_result_valid;
    logic                 o_independent;
    logic [ROW_IDX_W-1:0] o_pivot_row;
    t_col                 o_residue;
    logic [RANK_W-1:0]    o_rank_count;
    logic [NUL_W-1:0]     o_nullity_count;

    gf2_incremental_rank #(
        .ROWS       (ROWS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_column_bits   (i_column_bits),
        .i_start_new     (i_start_new),
        .o_result_valid  (o_result_valid),
        .o_independent   (o_independent),
        .o_pivot_row     (o_pivot_row),
        .o_residue       (o_residue),
        .o_rank_count    (o_rank_count),
        .o_nullity_count (o_nullity_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Columns still to be sent, and the results still owed by the block.
    t_column_item column_queue[$];
    t_outcome     expected_outcomes[$];

    // Columns queued since the last clear; their XOR combinations are dependent.
    t_col span_cols[$];

    int transfers_taken = 0;
    int results_seen    = 0;
    int mismatch_count  = 0;

    // Private copy of the elimination state. Reset leaves every pivot slot
    // unused, so the slots themselves need no clearing.
    t_col                  pivot_table [MAX_ROWS];
    t_col                  pivot_mask = '0;
    logic [RANK_W-1:0]     rank_q     = '0;
    logic [COUNT_BITS-1:0] seen_q     = '0;

    // Highest set row of a column; row zero for an empty column.
    function automatic int leading_row(t_col v);
        int r;
        r = MAX_ROWS - 1;
        while (r > 0 && !v[r])
            r--;
        return r;
    endfunction

    // Reduces one column against the pivot table, updates the table and the
    // counters, and returns what the block is expected to report.
    function automatic t_outcome reduce_column(t_col col_in, logic clear);
        t_outcome    res;
        t_col        col;
        int          h;
        int unsigned gap;
        col = col_in & ROW_MASK;
        res = '0;
        if (clear) begin
            pivot_mask = '0;
            rank_q     = '0;
            seen_q     = '0;
        end
        // XOR away the leading row for as long as that row owns a pivot.
        for (int iter = 0; iter < MAX_ROWS && col != '0; iter++) begin
            h = leading_row(col);
            if (!pivot_mask[h])
                break;
            col ^= pivot_table[h];
        end
        // Whatever survives is new: it becomes the pivot of its leading row.
        if (col != '0) begin
            h              = leading_row(col);
            pivot_table[h] = col;
            pivot_mask[h]  = 1'b1;
            if (rank_q < MAX_ROWS)
                rank_q++;
            res.indep   = 1'b1;
            res.prow    = ROW_IDX_W'(h);
            res.residue = col;
        end
        // The column count sticks at its maximum, so the nullity stops being
        // exact once it gets there.
        if (seen_q != '1)
            seen_q++;
        gap = (seen_q >= rank_q) ? seen_q - rank_q : 0;
        if (gap > (1 << NUL_W) - 1)
            gap = (1 << NUL_W) - 1;
        res.rank    = rank_q;
        res.nullity = NUL_W'(gap);
        return res;
    endfunction

    task automatic flag_mismatch(string what, t_col got, t_col want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("result %0d: %s is %h, expected %h", results_seen, what, got, want);
    endtask

    task automatic queue_column(t_col col, logic clear, logic hold);
        t_column_item item;
        item.col   = col;
        item.clear = clear;
        item.hold  = hold;
        column_queue.push_back(item);
        if (clear)
            span_cols.delete();
        if (col != '0)
            span_cols.push_back(col);
    endtask

    // Driver. Inputs change on the falling edge only. While no column is
    // offered, the payload ports carry noise that the block must ignore.
    // Idling is switched off over a stretch of transfers so that the chain
    // also sees long bursts of back-to-back columns.
    always @(negedge i_clk) begin : driver
        logic pause;
        logic quiet;
        pause = !i_rst_n || column_queue.size() == 0;
        quiet = transfers_taken >= 200 && transfers_taken < 450;
        if (!pause) begin
            pause = (column_queue[0].hold && expected_outcomes.size() != 0)
                 || (!quiet && $urandom_range(0, 99) < IDLE_PCT);
        end
        if (pause) begin
            start         <= 1'b0;
            i_column_bits <= {$urandom, $urandom};
            i_start_new   <= 1'($urandom_range(0, 1));
        end else begin
            start         <= 1'b1;
            i_column_bits <= column_queue[0].col;
            i_start_new   <= column_queue[0].clear;
        end
    end

    // Monitor. On each rising edge it first records a column transfer, which
    // yields the expected outcome for that column, and then checks a result
    // strobe against the oldest outcome still owed.
    always @(posedge i_clk) begin : monitor
        t_outcome want;
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_outcomes.push_back(reduce_column(i_column_bits, i_start_new));
                void'(column_queue.pop_front());
                transfers_taken++;
            end
            if (o_result_valid) begin
                if (expected_outcomes.size() == 0) begin
                    flag_mismatch("result with nothing owed, residue", o_residue, '0);
                end else begin
                    want = expected_outcomes.pop_front();
                    if (o_independent !== want.indep)
                        flag_mismatch("independent", t_col'(o_independent), t_col'(want.indep));
                    if (o_pivot_row !== want.prow)
                        flag_mismatch("pivot_row", t_col'(o_pivot_row), t_col'(want.prow));
                    if (o_residue !== want.residue)
                        flag_mismatch("residue", o_residue, want.residue);
                    if (o_rank_count !== want.rank)
                        flag_mismatch("rank_count", t_col'(o_rank_count), t_col'(want.rank));
                    if (o_nullity_count !== want.nullity)
                        flag_mismatch("nullity_count", t_col'(o_nullity_count),
                                      t_col'(want.nullity));
                end
                results_seen++;
            end
        end
    end

    // Stimulus, reset and the end of the run.
    initial begin : stimulus
        int        produced;
        int        len;
        int        dense_pct;
        t_col_kind kind;
        t_col      c;
        logic      clear;
        logic      hold;

        // Directed part. All ones first, so that row 63 owns a pivot; then the
        // same column again, which is dependent, and an empty column.
        queue_column('1, 1'b1, 1'b0);
        queue_column('1, 1'b0, 1'b0);
        queue_column('0, 1'b0, 1'b0);
        queue_column(t_col'(1), 1'b0, 1'b0);
        // The top row alone reduces against all ones and lands on row 62.
        queue_column(t_col'(1) << 63, 1'b0, 1'b0);
        queue_column(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0);
        queue_column(64'h5555_5555_5555_5555, 1'b0, 1'b1);
        queue_column(64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b0);
        // Clears: an empty column right after a clear, then clears back to back.
        queue_column('0, 1'b1, 1'b0);
        queue_column(t_col'(1), 1'b1, 1'b0);
        queue_column(t_col'(1) << 63, 1'b1, 1'b0);
        // Columns with the same leading row follow each other closely.
        queue_column(64'h0000_0000_0000_00F0, 1'b0, 1'b0);
        queue_column(64'h0000_0000_0000_00F1, 1'b0, 1'b0);
        queue_column(64'h0000_0000_0000_0001, 1'b0, 1'b0);
        queue_column(64'h0123_4567_89AB_CDEF, 1'b0, 1'b0);
        queue_column(64'h0123_4567_89AB_CDEF, 1'b0, 1'b0);
        queue_column(64'h0123_4567_89AB_CD1E, 1'b0, 1'b0);
        queue_column(t_col'(1) << 1, 1'b0, 1'b0);
        queue_column(t_col'(1) << 31, 1'b0, 1'b0);
        queue_column(t_col'(1) << 32, 1'b0, 1'b0);
        queue_column(t_col'(1) << 62, 1'b0, 1'b0);

        // Random part: runs that each start with a clear. Long runs are mostly
        // dense, so they can reach full rank; short ones mix in more sparse, single-bit
        // and empty columns and combinations of earlier columns of the run.
        produced = 0;
        while (produced < RANDOM_ITEMS) begin
            len       = ($urandom_range(0, 4) == 0) ? $urandom_range(64, 90)
                                                    : $urandom_range(1, 30);
            dense_pct = (len >= 64) ? 75 : 35;
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 99) < dense_pct)
                    kind = KIND_DENSE;
                else
                    kind = t_col_kind'($urandom_range(1, 4));
                c = '0;
                case (kind)
                    KIND_DENSE: begin
                        c = {$urandom, $urandom};
                    end
                    KIND_SPARSE: begin
                        repeat ($urandom_range(1, 3))
                            c[$urandom_range(0, MAX_ROWS - 1)] = 1'b1;
                    end
                    KIND_COMBO: begin
                        foreach (span_cols[j])
                            if ($urandom_range(0, 1) == 1)
                                c ^= span_cols[j];
                    end
                    KIND_ZERO: begin
                        c = '0;
                    end
                    default: begin
                        c = t_col'(1) << $urandom_range(0, MAX_ROWS - 1);
                    end
                endcase
                clear = (i == 0) || ($urandom_range(0, 49) == 0);
                hold  = (i == 0) && ($urandom_range(0, 3) == 0);
                queue_column(c, clear, hold);
                produced++;
            end
        end

        // Tail: a run of empty columns that raises only the nullity, then new
        // columns that raise only the rank, and finally a clear that restarts
        // both counters.
        queue_column('0, 1'b1, 1'b1);
        repeat (TAIL_ZEROS)
            queue_column('0, 1'b0, 1'b0);
        repeat (20)
            queue_column({$urandom, $urandom}, 1'b0, 1'b0);
        queue_column({$urandom, $urandom}, 1'b1, 1'b1);
        repeat (5)
            queue_column({$urandom, $urandom}, 1'b0, 1'b0);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (column_queue.size() != 0)
            @(negedge i_clk);
        while (expected_outcomes.size() != 0)
            @(negedge i_clk);
        // Any stray strobe after the last owed result is still caught here.
        repeat (LATENCY + 8) @(negedge i_clk);

        if (mismatch_count == 0)
            $display("gf2_incremental_rank_test OK");
        else
            $display("gf2_incremental_rank_test NOT OK");
        $finish;
    end

    // Watchdog against a hung handshake or results that never arrive.
    initial begin : watchdog
        #(TIMEOUT_CYCLES * 4);
        $display("gf2_incremental_rank_test NOT OK");
        $finish;
    end

endmodule

>>> sim.f
sv/gir_pkg.sv
sv/gir_cell.sv
sv/gir_tally.sv
sv/gf2_incremental_rank.sv
verif/gf2_incremental_rank_test.sv
